// ===== rtl/core/zsbu_pkg.sv =====
// Shared constants and types for the zero-stuffing biquad upsampler.
`timescale 1ns / 1ps

package zsbu_pkg;

  localparam int DEF_CHANNELS    = 2;
  localparam int DEF_MAX_FACTOR  = 4;
  localparam int DEF_SAMPLE_BITS = 24;

  localparam int COEF_BITS   = 32;
  localparam int FACTOR_BITS = 3;
  localparam int CHAN_BITS   = 1;
  localparam int FRAC_BITS   = 30;
  localparam int ACC_GUARD   = 3;
  localparam int REG_IDX_BITS = 3;

  localparam logic [REG_IDX_BITS-1:0] REG_FACTOR  = 3'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_COEF_B0 = 3'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_COEF_B1 = 3'd2;
  localparam logic [REG_IDX_BITS-1:0] REG_COEF_B2 = 3'd3;
  localparam logic [REG_IDX_BITS-1:0] REG_COEF_A1 = 3'd4;
  localparam logic [REG_IDX_BITS-1:0] REG_COEF_A2 = 3'd5;

  localparam logic signed [COEF_BITS-1:0] COEF_ONE = 32'sd1073741824;

  typedef struct packed {
    logic issue;
    logic accum;
    logic negate;
    logic clear;
  } mac_ctrl_t;

endpackage

// ===== rtl/core/zero_stuff_biquad_upsampler_core.sv =====
// Top level of the zero-stuffing biquad upsampler with a shared multiply-accumulate unit.
`timescale 1ns / 1ps

// Usage: an input transfer carries a channel index and one sample. The sample
// is scaled by the oversampling factor and followed by factor-1 zeros; each of
// these values runs through the biquad of that channel, and each filtered value
// leaves as one result transfer. The final result of the run has last_of_run set.
// Input samples on a channel that does not exist give no result.
// One multiplier serves all five filter taps and the initial scaling. The sample
// passes the scale and load states, then each value the five tap steps, the drain
// state and the output state, where its result is registered; the next item is
// accepted only once the block is back in idle, never during a run.
// sample_stall is high for the whole run of an item. A stalled result holds in
// the output register and the run pauses until it is taken; the final result may
// wait there while the next item is accepted.
// Synchronous reset restores the default factor and coefficients, clears all
// filter history and empties the output register. Registers are to be written
// only while the block is idle; the block itself does not enforce this.
module zero_stuff_biquad_upsampler_core
  import zsbu_pkg::*;
#(
  parameter int CHANNELS    = DEF_CHANNELS,
  parameter int MAX_FACTOR  = DEF_MAX_FACTOR,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [REG_IDX_BITS-1:0]       wr_index,
  input  logic [COEF_BITS-1:0]          wr_data,
  input  logic                          sample_valid,
  output logic                          sample_stall,
  input  logic [CHAN_BITS-1:0]          chan,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic [CHAN_BITS-1:0]          chan_out,
  output logic signed [SAMPLE_BITS-1:0] sample_out,
  output logic                          last_of_run
);

  localparam int XW   = SAMPLE_BITS + $clog2(MAX_FACTOR);
  localparam int PW   = COEF_BITS + XW;
  localparam int ACCW = PW + ACC_GUARD;
  localparam int FW   = $clog2(MAX_FACTOR + 1);
  localparam int CIW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int EXT  = XW - SAMPLE_BITS;
  localparam logic [2:0] LAST_STEP = 3'd4;
  localparam logic signed [ACCW-1:0] SAT_HI = ACCW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [ACCW-1:0] SAT_LO = -SAT_HI - ACCW'(1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_LOAD_X,
    ST_MUL,
    ST_DRAIN,
    ST_OUT
  } state_t;

  state_t state;

  logic [FACTOR_BITS-1:0]       factor;
  logic signed [COEF_BITS-1:0]  coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;

  logic signed [XW-1:0]          x1_mem [CHANNELS];
  logic signed [XW-1:0]          x2_mem [CHANNELS];
  logic signed [SAMPLE_BITS-1:0] y1_mem [CHANNELS];
  logic signed [SAMPLE_BITS-1:0] y2_mem [CHANNELS];

  logic [CIW-1:0]                ch;
  logic [CHAN_BITS-1:0]          ch_raw;
  logic signed [SAMPLE_BITS-1:0] smp;
  logic signed [XW-1:0]          xv, x1, x2;
  logic signed [SAMPLE_BITS-1:0] y1, y2;
  logic [2:0]                    step;
  logic [FW-1:0]                 run;

  logic [FW-1:0]                 f_eff;
  logic [31:0]                   factor_wide;
  logic                          last_value;
  logic [CIW-1:0]                ch_in;

  mac_ctrl_t                     ctl;
  logic signed [COEF_BITS-1:0]   ma;
  logic signed [XW-1:0]          mb;
  logic signed [PW-1:0]          prod;
  logic signed [ACCW-1:0]        acc;
  logic signed [ACCW-1:0]        shifted;
  logic signed [SAMPLE_BITS-1:0] y_val;

  assign factor_wide = 32'(factor);
  assign ch_in       = CIW'(chan);

  always_comb begin
    if (factor == '0) begin
      f_eff = FW'(1);
    end else if (factor_wide > 32'(MAX_FACTOR)) begin
      f_eff = FW'(MAX_FACTOR);
    end else begin
      f_eff = FW'(factor_wide);
    end
  end

  assign last_value   = ((run + FW'(1)) == f_eff);
  assign sample_stall = (state != ST_IDLE);

  assign shifted = acc >>> FRAC_BITS;

  always_comb begin
    if (shifted > SAT_HI) begin
      y_val = SAT_HI[SAMPLE_BITS-1:0];
    end else if (shifted < SAT_LO) begin
      y_val = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      y_val = shifted[SAMPLE_BITS-1:0];
    end
  end

  always_comb begin
    ctl = '0;
    ma  = coef_b0;
    mb  = xv;
    case (state)
      ST_SCALE: begin
        ctl.issue = 1'b1;
        ma        = COEF_BITS'(f_eff);
        mb        = {{EXT{smp[SAMPLE_BITS-1]}}, smp};
      end
      ST_MUL: begin
        ctl.issue = 1'b1;
        ctl.accum = 1'b1;
        ctl.clear = (step == '0);
        case (step)
          3'd0: begin
            ma = coef_b0;
            mb = xv;
          end
          3'd1: begin
            ma = coef_b1;
            mb = x1;
          end
          3'd2: begin
            ma = coef_b2;
            mb = x2;
          end
          3'd3: begin
            ma         = coef_a1;
            mb         = {{EXT{y1[SAMPLE_BITS-1]}}, y1};
            ctl.negate = 1'b1;
          end
          3'd4: begin
            ma         = coef_a2;
            mb         = {{EXT{y2[SAMPLE_BITS-1]}}, y2};
            ctl.negate = 1'b1;
          end
          default: begin
            ma = coef_b0;
            mb = xv;
          end
        endcase
      end
      default: begin
        ctl = '0;
      end
    endcase
  end

  zsbu_mac #(
    .XW(XW)
  ) u_mac (
    .clk (clk),
    .rst (rst),
    .ctl (ctl),
    .ma  (ma),
    .mb  (mb),
    .prod(prod),
    .acc (acc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      factor  <= FACTOR_BITS'(1);
      coef_b0 <= COEF_ONE;
      coef_b1 <= '0;
      coef_b2 <= '0;
      coef_a1 <= '0;
      coef_a2 <= '0;
    end else if (wr_en) begin
      case (wr_index)
        REG_FACTOR:  factor  <= wr_data[FACTOR_BITS-1:0];
        REG_COEF_B0: coef_b0 <= wr_data;
        REG_COEF_B1: coef_b1 <= wr_data;
        REG_COEF_B2: coef_b2 <= wr_data;
        REG_COEF_A1: coef_a1 <= wr_data;
        REG_COEF_A2: coef_a2 <= wr_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
      step         <= '0;
      run          <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        x1_mem[i] <= '0;
        x2_mem[i] <= '0;
        y1_mem[i] <= '0;
        y2_mem[i] <= '0;
      end
    end else begin
      if (result_valid && !result_stall && (state != ST_OUT)) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (sample_valid && (32'(chan) < 32'(CHANNELS))) begin
            ch     <= ch_in;
            ch_raw <= chan;
            smp    <= sample_in;
            x1     <= x1_mem[ch_in];
            x2     <= x2_mem[ch_in];
            y1     <= y1_mem[ch_in];
            y2     <= y2_mem[ch_in];
            run    <= '0;
            state  <= ST_SCALE;
          end
        end
        ST_SCALE: begin
          state <= ST_LOAD_X;
        end
        ST_LOAD_X: begin
          xv    <= prod[XW-1:0];
          step  <= '0;
          state <= ST_MUL;
        end
        ST_MUL: begin
          if (step == LAST_STEP) begin
            state <= ST_DRAIN;
          end else begin
            step <= step + 3'd1;
          end
        end
        ST_DRAIN: begin
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (!result_valid || !result_stall) begin
            result_valid <= 1'b1;
            chan_out     <= ch_raw;
            sample_out   <= y_val;
            last_of_run  <= last_value;
            xv           <= '0;
            x1           <= xv;
            x2           <= x1;
            y1           <= y_val;
            y2           <= y1;
            if (last_value) begin
              x1_mem[ch] <= xv;
              x2_mem[ch] <= x1;
              y1_mem[ch] <= y_val;
              y2_mem[ch] <= y1;
              state      <= ST_IDLE;
            end else begin
              run   <= run + FW'(1);
              step  <= '0;
              state <= ST_MUL;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/zsbu_mac.sv =====
// Shared multiplier with registered product and signed accumulator.
`timescale 1ns / 1ps

module zsbu_mac
  import zsbu_pkg::*;
#(
  parameter int XW = 26
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  mac_ctrl_t                                 ctl,
  input  logic signed [COEF_BITS-1:0]               ma,
  input  logic signed [XW-1:0]                      mb,
  output logic signed [COEF_BITS+XW-1:0]            prod,
  output logic signed [COEF_BITS+XW+ACC_GUARD-1:0]  acc
);

  localparam int PW   = COEF_BITS + XW;
  localparam int ACCW = PW + ACC_GUARD;

  logic p_acc;
  logic p_neg;
  logic signed [ACCW-1:0] prod_ext;

  assign prod_ext = ACCW'(prod);

  always_ff @(posedge clk) begin
    if (ctl.issue) begin
      prod <= PW'(ma) * PW'(mb);
    end
    if (rst) begin
      p_acc <= 1'b0;
      p_neg <= 1'b0;
    end else begin
      p_acc <= ctl.issue & ctl.accum;
      p_neg <= ctl.negate;
    end
    if (ctl.clear) begin
      acc <= '0;
    end else if (p_acc) begin
      acc <= p_neg ? (acc - prod_ext) : (acc + prod_ext);
    end
  end

endmodule

// ===== dv/zero_stuff_biquad_upsampler_core_tb.sv =====
// Self-checking testbench for the zero-stuffing biquad upsampler core.
`timescale 1ns / 1ps

module zero_stuff_biquad_upsampler_core_tb;
  import zsbu_pkg::*;

  localparam int CHANNELS    = DEF_CHANNELS;
  localparam int MAX_FACTOR  = DEF_MAX_FACTOR;
  localparam int SAMPLE_BITS = DEF_SAMPLE_BITS;
  localparam int HIST_BITS   = SAMPLE_BITS + 2;
  localparam int DRAIN_CYCLES = 40;

  localparam logic [REG_IDX_BITS-1:0] REG_UNUSED_LO = 3'd6;
  localparam logic [REG_IDX_BITS-1:0] REG_UNUSED_HI = 3'd7;

  localparam longint SAMPLE_MAX = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
  localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;

  localparam logic signed [SAMPLE_BITS-1:0] S_MAX = SAMPLE_MAX[SAMPLE_BITS-1:0];
  localparam logic signed [SAMPLE_BITS-1:0] S_MIN = SAMPLE_MIN[SAMPLE_BITS-1:0];

  localparam logic [COEF_BITS-1:0] C_MAX = 32'h7FFF_FFFF;
  localparam logic [COEF_BITS-1:0] C_MIN = 32'h8000_0000;
  localparam logic [COEF_BITS-1:0] LP_B0 = 32'h0400_0000;
  localparam logic [COEF_BITS-1:0] LP_B1 = 32'h0800_0000;
  localparam logic [COEF_BITS-1:0] LP_A1 = 32'hC000_0000;
  localparam logic [COEF_BITS-1:0] LP_A2 = 32'h1000_0000;

  class biquad_scoreboard;
    typedef struct {
      logic [CHAN_BITS-1:0]          chan;
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          last;
    } upsampled_t;

    upsampled_t expected_outputs[$];
    int errors = 0;

    logic [FACTOR_BITS-1:0]      factor = 3'd1;
    logic signed [COEF_BITS-1:0] b0 = COEF_ONE;
    logic signed [COEF_BITS-1:0] b1 = '0;
    logic signed [COEF_BITS-1:0] b2 = '0;
    logic signed [COEF_BITS-1:0] a1 = '0;
    logic signed [COEF_BITS-1:0] a2 = '0;

    logic signed [HIST_BITS-1:0]   in_one[CHANNELS]  = '{default: '0};
    logic signed [HIST_BITS-1:0]   in_two[CHANNELS]  = '{default: '0};
    logic signed [SAMPLE_BITS-1:0] out_one[CHANNELS] = '{default: '0};
    logic signed [SAMPLE_BITS-1:0] out_two[CHANNELS] = '{default: '0};

    function void set_reg(logic [REG_IDX_BITS-1:0] idx, logic [COEF_BITS-1:0] data);
      case (idx)
        REG_FACTOR:  factor = data[FACTOR_BITS-1:0];
        REG_COEF_B0: b0 = data;
        REG_COEF_B1: b1 = data;
        REG_COEF_B2: b2 = data;
        REG_COEF_A1: a1 = data;
        REG_COEF_A2: a2 = data;
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_outputs.size();
    endfunction

    function void note_sample(logic [CHAN_BITS-1:0] ch, logic signed [SAMPLE_BITS-1:0] s);
      int f;
      longint xv;
      longint acc;
      upsampled_t e;
      if (ch >= CHANNELS) return;
      f = (factor == 0) ? 1 : (factor > MAX_FACTOR) ? MAX_FACTOR : int'(factor);
      for (int j = 0; j < f; j++) begin
        xv = (j == 0) ? longint'(s) * f : 0;
        acc = longint'(b0) * xv + longint'(b1) * longint'(in_one[ch])
            + longint'(b2) * longint'(in_two[ch]) - longint'(a1) * longint'(out_one[ch])
            - longint'(a2) * longint'(out_two[ch]);
        acc = acc >>> FRAC_BITS;
        if (acc > SAMPLE_MAX) acc = SAMPLE_MAX;
        else if (acc < SAMPLE_MIN) acc = SAMPLE_MIN;
        in_two[ch]  = in_one[ch];
        in_one[ch]  = xv[HIST_BITS-1:0];
        out_two[ch] = out_one[ch];
        out_one[ch] = acc[SAMPLE_BITS-1:0];
        e.chan   = ch;
        e.sample = acc[SAMPLE_BITS-1:0];
        e.last   = (j == f - 1);
        expected_outputs.push_back(e);
      end
    endfunction

    function void check_result(logic [CHAN_BITS-1:0] ch, logic signed [SAMPLE_BITS-1:0] s,
                               logic last);
      upsampled_t e;
      if (expected_outputs.size() == 0) begin
        $display("%0t: unexpected transfer chan=%0d sample=%0d last=%0b", $time, ch, s, last);
        errors++;
        return;
      end
      e = expected_outputs.pop_front();
      if (ch !== e.chan) begin
        $display("%0t: chan_out expected %0d actual %0d", $time, e.chan, ch);
        errors++;
      end
      if (s !== e.sample) begin
        $display("%0t: sample_out expected %0d actual %0d", $time, e.sample, s);
        errors++;
      end
      if (last !== e.last) begin
        $display("%0t: last_of_run expected %0b actual %0b", $time, e.last, last);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic wr_en = 1'b0;
  logic [REG_IDX_BITS-1:0] wr_index = '0;
  logic [COEF_BITS-1:0] wr_data = '0;
  logic sample_valid = 1'b0;
  logic sample_stall;
  logic [CHAN_BITS-1:0] chan = '0;
  logic signed [SAMPLE_BITS-1:0] sample_in = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic [CHAN_BITS-1:0] chan_out;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic last_of_run;

  logic hold_results = 1'b0;
  int sample_idle_pct = 0;
  int result_stall_pct = 0;

  biquad_scoreboard sb = new();

  zero_stuff_biquad_upsampler_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .wr_en        (wr_en),
    .wr_index     (wr_index),
    .wr_data      (wr_data),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .chan         (chan),
    .sample_in    (sample_in),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .chan_out     (chan_out),
    .sample_out   (sample_out),
    .last_of_run  (last_of_run)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      sb.check_result(chan_out, sample_out, last_of_run);
    end
    result_stall <= hold_results || ($urandom_range(99) < result_stall_pct);
  end

  task automatic write_reg(logic [REG_IDX_BITS-1:0] idx, logic [COEF_BITS-1:0] data);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
    wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_filter(logic [FACTOR_BITS-1:0] f, logic [COEF_BITS-1:0] c_b0,
                                logic [COEF_BITS-1:0] c_b1, logic [COEF_BITS-1:0] c_b2,
                                logic [COEF_BITS-1:0] c_a1, logic [COEF_BITS-1:0] c_a2);
    write_reg(REG_FACTOR, {(COEF_BITS - FACTOR_BITS)'($urandom), f});
    write_reg(REG_COEF_B0, c_b0);
    write_reg(REG_COEF_B1, c_b1);
    write_reg(REG_COEF_B2, c_b2);
    write_reg(REG_COEF_A1, c_a1);
    write_reg(REG_COEF_A2, c_a2);
  endtask

  task automatic send_sample(logic [CHAN_BITS-1:0] ch, logic signed [SAMPLE_BITS-1:0] s);
    while ($urandom_range(99) < sample_idle_pct) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    chan         <= ch;
    sample_in    <= s;
    do @(posedge clk); while (sample_stall);
    sb.note_sample(ch, s);
  endtask

  // Called in the step of the last input transfer, so the valid is lowered only once.
  task automatic settle();
    sample_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(9))
      0: return S_MAX;
      1: return S_MIN;
      2: return '0;
      3: return SAMPLE_BITS'(int'($urandom_range(255)) - 128);
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [COEF_BITS-1:0] rand_coef();
    return $signed($urandom) >>> $urandom_range(8);
  endfunction

  task automatic run_phase(int items, int send_idle, int stall, int hold);
    sample_idle_pct  = send_idle;
    result_stall_pct = stall;
    if (hold > 0) begin
      fork
        begin
          hold_results <= 1'b1;
          repeat (hold) @(posedge clk);
          hold_results <= 1'b0;
        end
      join_none
    end
    repeat (items) send_sample(CHAN_BITS'($urandom_range(1)), pick_sample());
    settle();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset configuration passes samples straight through.
    send_sample(1'b0, S_MAX);
    send_sample(1'b1, S_MIN);
    send_sample(1'b0, '0);
    send_sample(1'b1, '1);
    send_sample(1'b0, 24'sd1);
    send_sample(1'b1, 24'sh555555);
    send_sample(1'b0, 24'shAAAAAA);
    settle();

    // Extreme coefficients at the largest factor drive the output into saturation.
    program_filter(3'd4, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX);
    send_sample(1'b0, S_MAX);
    send_sample(1'b1, S_MIN);
    send_sample(1'b1, S_MAX);
    send_sample(1'b0, S_MIN);
    settle();

    // A factor of zero acts as one, and writes to unused indexes change nothing.
    program_filter(3'd0, LP_B0, LP_B1, LP_B0, LP_A1, LP_A2);
    write_reg(REG_UNUSED_LO, 32'h1234_5678);
    write_reg(REG_UNUSED_HI, 32'hFFFF_FFFF);
    send_sample(1'b0, S_MAX);
    send_sample(1'b1, S_MIN);
    send_sample(1'b0, 24'sh123456);
    settle();

    // Factors above the maximum are clamped.
    write_reg(REG_FACTOR, 32'd7);
    send_sample(1'b1, S_MAX);
    send_sample(1'b0, 24'sh400000);
    send_sample(1'b1, '0);
    settle();
    write_reg(REG_FACTOR, 32'd5);
    send_sample(1'b0, S_MIN);
    send_sample(1'b1, 24'sh7);
    settle();

    program_filter(3'd4, LP_B0, LP_B1, LP_B0, LP_A1, LP_A2);
    run_phase(38, 0, 0, 0);
    program_filter(FACTOR_BITS'($urandom_range(1, 4)), rand_coef(), rand_coef(),
                   rand_coef(), rand_coef(), rand_coef());
    run_phase(38, 60, 0, 0);
    program_filter(3'd2, LP_B0, LP_B1, LP_B0, LP_A1, LP_A2);
    run_phase(38, 0, 60, 0);
    program_filter(3'd3, rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef());
    run_phase(38, 34, 34, 0);
    program_filter(3'd4, LP_B0, LP_B1, LP_B0, LP_A1, LP_A2);
    run_phase(38, 0, 0, 300);
    program_filter(FACTOR_BITS'($urandom_range(7)), rand_coef(), rand_coef(),
                   rand_coef(), rand_coef(), rand_coef());
    run_phase(40, 34, 34, 0);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
